[rtl/bscp_pkg.sv]
package bscp_pkg;

	typedef logic [1:0] axis_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

endpackage

[rtl/bscp_sqrt.sv]
module bscp_sqrt import bscp_pkg::*; #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  logic [2*W-1:0] rad,
	output logic           out_vld,
	output logic [W-1:0]   root
);

	localparam int RW = W + 2;

	logic           vld_q  [1:W];
	logic [RW-1:0]  rem_q  [1:W];
	logic [W-1:0]   root_q [1:W];
	logic [2*W-1:0] rad_q  [1:W];

	// one result bit per stage, restoring
	for (genvar k = 0; k < W; k++) begin : g_st
		logic [RW-1:0]  c_rem;
		logic [W-1:0]   c_root;
		logic [2*W-1:0] c_rad;
		logic           c_vld;
		logic [RW:0]    t;
		logic [RW:0]    trial;
		logic [RW:0]    diff;
		logic           ge;

		if (k == 0) begin : g_in
			assign c_rem  = '0;
			assign c_root = '0;
			assign c_rad  = rad;
			assign c_vld  = in_vld;
		end else begin : g_mid
			assign c_rem  = rem_q[k];
			assign c_root = root_q[k];
			assign c_rad  = rad_q[k];
			assign c_vld  = vld_q[k];
		end

		assign t     = {c_rem[RW-2:0], c_rad[2*W-1 -: 2]};
		assign trial = {1'b0, c_root, 2'b01};
		assign ge    = (t >= trial);
		assign diff  = t - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= c_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k+1]  <= ge ? diff[RW-1:0] : t[RW-1:0];
			root_q[k+1] <= {c_root[W-2:0], ge};
			rad_q[k+1]  <= {c_rad[2*W-3:0], 2'b00};
		end
	end

	assign out_vld = vld_q[W];
	assign root    = root_q[W];

endmodule

[rtl/bscp_div.sv]
module bscp_div import bscp_pkg::*; #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  logic [2*W-3:0] num [3],
	input  logic [W-1:0]   den,
	output logic           out_vld,
	output logic [W-2:0]   quo [3]
);

	localparam int Q = W - 1;
	localparam int N = 2 * W - 2;

	logic         vld_q [1:Q];
	logic [W-1:0] den_q [1:Q];
	logic [W-1:0] rem_q [1:Q][3];
	logic [Q-1:0] low_q [1:Q][3];
	logic [Q-1:0] quo_q [1:Q][3];

	// three lanes share the divisor; one quotient bit per stage
	for (genvar k = 0; k < Q; k++) begin : g_st
		logic         c_vld;
		logic [W-1:0] c_den;
		logic [W-1:0] c_rem [3];
		logic [Q-1:0] c_low [3];
		logic [Q-1:0] c_quo [3];

		if (k == 0) begin : g_in
			assign c_vld = in_vld;
			assign c_den = den;
			for (genvar l = 0; l < 3; l++) begin : g_ln
				assign c_rem[l] = {1'b0, num[l][N-1:Q]};
				assign c_low[l] = num[l][Q-1:0];
				assign c_quo[l] = '0;
			end
		end else begin : g_mid
			assign c_vld = vld_q[k];
			assign c_den = den_q[k];
			for (genvar l = 0; l < 3; l++) begin : g_ln
				assign c_rem[l] = rem_q[k][l];
				assign c_low[l] = low_q[k][l];
				assign c_quo[l] = quo_q[k][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= c_vld;
			end
		end

		always_ff @(posedge clk) begin
			den_q[k+1] <= c_den;
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [W:0] t;
			logic [W:0] diff;
			logic       ge;

			assign t    = {c_rem[l], c_low[l][Q-1]};
			assign ge   = (t >= {1'b0, c_den});
			assign diff = t - {1'b0, c_den};

			always_ff @(posedge clk) begin
				rem_q[k+1][l] <= ge ? diff[W-1:0] : t[W-1:0];
				low_q[k+1][l] <= {c_low[l][Q-2:0], 1'b0};
				quo_q[k+1][l] <= {c_quo[l][Q-2:0], ge};
			end
		end
	end

	assign out_vld = vld_q[Q];
	for (genvar l = 0; l < 3; l++) begin : g_out
		assign quo[l] = quo_q[Q][l];
	end

endmodule

[rtl/box_sphere_collision_push.sv]
// Box / sphere overlap test with push vector, signed fixed point (Q16.16 at 32 bits).
//
// Input: drive the box and ball fields and pulse start. A transfer happens on
// each rising edge with start high and busy low. busy is always low: the
// pipeline takes one pair every clock.
//
// Output: done is high for exactly one cycle per pair, in input order, with
// hit and push_x/y/z valid in that cycle. The receiver cannot stall, and
// none is needed: results leave at the rate pairs enter.
//
// The pipeline holds the bit-per-stage square root (COORD_BITS stages) and
// the bit-per-stage divider (COORD_BITS-1 stages) that scale the push for a
// sphere centre outside the box.
// Throughput: one pair per cycle.
//
// Reset: arst_n clears all valid bits; pairs in flight are dropped and no
// done pulse follows until new pairs are taken.
module box_sphere_collision_push import bscp_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] box_center_x,
	input  logic signed [COORD_BITS-1:0] box_center_y,
	input  logic signed [COORD_BITS-1:0] box_center_z,
	input  logic        [COORD_BITS-2:0] box_half_x,
	input  logic        [COORD_BITS-2:0] box_half_y,
	input  logic        [COORD_BITS-2:0] box_half_z,
	input  logic signed [COORD_BITS-1:0] ball_center_x,
	input  logic signed [COORD_BITS-1:0] ball_center_y,
	input  logic signed [COORD_BITS-1:0] ball_center_z,
	input  logic        [COORD_BITS-2:0] ball_radius,
	output logic                         done,
	output logic                         hit,
	output logic signed [COORD_BITS-1:0] push_x,
	output logic signed [COORD_BITS-1:0] push_y,
	output logic signed [COORD_BITS-1:0] push_z
);

	localparam int W = COORD_BITS;

	typedef struct packed {
		logic                  hit;
		logic                  outs;
		logic [2:0]            neg;
		logic [W-2:0]          r;
		logic [2:0][W-2:0]     m;
		logic [2:0][W-1:0]     push;
	} side_t;

	typedef struct packed {
		logic              hit;
		logic              outs;
		logic [2:0]        neg;
		logic [2:0][W-1:0] push;
	} tail_t;

	function automatic logic [W-1:0] pack(input logic [W-1:0] mag, input logic neg);
		logic [W-1:0] hmax;
		logic [W-1:0] nmax;
		logic [W-1:0] lim;
		hmax = {1'b0, {(W-1){1'b1}}};
		nmax = {1'b1, {(W-1){1'b0}}};
		if (neg) begin
			lim = (mag > nmax) ? nmax : mag;
			return -lim;
		end else begin
			return (mag > hmax) ? hmax : mag;
		end
	endfunction

	assign busy = 1'b0;

	// stage 1: input registers
	logic                v_s1;
	logic signed [W-1:0] bc_s1 [3];
	logic [W-2:0]        bh_s1 [3];
	logic signed [W-1:0] sc_s1 [3];
	logic [W-2:0]        r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		bc_s1[0] <= box_center_x;
		bc_s1[1] <= box_center_y;
		bc_s1[2] <= box_center_z;
		bh_s1[0] <= box_half_x;
		bh_s1[1] <= box_half_y;
		bh_s1[2] <= box_half_z;
		sc_s1[0] <= ball_center_x;
		sc_s1[1] <= ball_center_y;
		sc_s1[2] <= ball_center_z;
		r_s1     <= ball_radius;
	end

	// stage 2: slab gaps and clamp offsets
	logic                  gmiss   [3];
	logic [W-1:0]          gap     [3];
	logic                  dneg    [3];
	logic [W-2:0]          cm      [3];
	logic                  cneg    [3];
	logic                  cnz     [3];
	logic signed [W:0]     dd      [3];
	logic [W:0]            ad      [3];
	logic [W-1:0]          hr      [3];
	logic signed [W+1:0]   bhi     [3];
	logic signed [W+1:0]   blo     [3];
	logic signed [W+1:0]   sx      [3];
	logic signed [W+1:0]   mm      [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dd[i]    = $signed({bc_s1[i][W-1], bc_s1[i]}) - $signed({sc_s1[i][W-1], sc_s1[i]});
			ad[i]    = dd[i][W] ? (~dd[i] + 1'b1) : dd[i];
			hr[i]    = {1'b0, bh_s1[i]} + {1'b0, r_s1};
			gmiss[i] = (ad[i] >= {1'b0, hr[i]});
			gap[i]   = hr[i] - ad[i][W-1:0];
			dneg[i]  = dd[i][W];
			bhi[i]   = $signed({{2{bc_s1[i][W-1]}}, bc_s1[i]}) + $signed({3'b000, bh_s1[i]});
			blo[i]   = $signed({{2{bc_s1[i][W-1]}}, bc_s1[i]}) - $signed({3'b000, bh_s1[i]});
			sx[i]    = $signed({{2{sc_s1[i][W-1]}}, sc_s1[i]});
			if (sx[i] > bhi[i]) begin
				mm[i]   = sx[i] - bhi[i];
				cneg[i] = 1'b1;
				cnz[i]  = 1'b1;
			end else if (sx[i] < blo[i]) begin
				mm[i]   = blo[i] - sx[i];
				cneg[i] = 1'b0;
				cnz[i]  = 1'b1;
			end else begin
				mm[i]   = '0;
				cneg[i] = 1'b0;
				cnz[i]  = 1'b0;
			end
			cm[i] = mm[i][W-2:0];
		end
	end

	logic         v_s2;
	logic         miss_s2;
	logic         inside_s2;
	logic [W-1:0] g_s2    [3];
	logic [2:0]   dneg_s2;
	logic [2:0]   neg_s2;
	logic [W-2:0] m_s2    [3];
	logic [W-2:0] r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		miss_s2   <= gmiss[0] || gmiss[1] || gmiss[2];
		inside_s2 <= !(cnz[0] || cnz[1] || cnz[2]);
		for (int i = 0; i < 3; i++) begin
			g_s2[i]    <= gap[i];
			dneg_s2[i] <= dneg[i];
			neg_s2[i]  <= cneg[i];
			m_s2[i]    <= cm[i];
		end
		r_s2 <= r_s1;
	end

	// stage 3: inside push, squares
	axis_t ax;
	side_t side_c3;

	always_comb begin
		if (g_s2[0] < g_s2[1]) begin
			ax = (g_s2[2] < g_s2[0]) ? AXIS_Z : AXIS_X;
		end else begin
			ax = (g_s2[2] < g_s2[1]) ? AXIS_Z : AXIS_Y;
		end
		side_c3.hit  = !miss_s2 && inside_s2;
		side_c3.outs = !miss_s2 && !inside_s2;
		side_c3.neg  = neg_s2;
		side_c3.r    = r_s2;
		side_c3.m[0] = m_s2[0];
		side_c3.m[1] = m_s2[1];
		side_c3.m[2] = m_s2[2];
		side_c3.push = '0;
		if (!miss_s2 && inside_s2) begin
			case (ax)
				AXIS_X:  side_c3.push[0] = pack(g_s2[0], dneg_s2[0]);
				AXIS_Y:  side_c3.push[1] = pack(g_s2[1], dneg_s2[1]);
				AXIS_Z:  side_c3.push[2] = pack(g_s2[2], dneg_s2[2]);
				default: side_c3.push    = '0;
			endcase
		end
	end

	logic           v_s3;
	side_t          side_s3;
	logic [2*W-3:0] sq_s3 [3];
	logic [2*W-3:0] rr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_c3;
		for (int i = 0; i < 3; i++) begin
			sq_s3[i] <= m_s2[i] * m_s2[i];
		end
		rr_s3 <= r_s2 * r_s2;
	end

	// stage 4: squared distance against r squared
	logic [2*W-1:0] sum_c4;
	side_t          side_c4;
	logic           v_s4;
	side_t          side_s4;
	logic [2*W-1:0] sum_s4;

	assign sum_c4 = {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};

	always_comb begin
		side_c4      = side_s3;
		side_c4.outs = side_s3.outs && ({2'b00, rr_s3} > sum_c4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_c4;
		sum_s4  <= sum_c4;
	end

	logic         sq_vld;
	logic [W-1:0] sq_root;

	bscp_sqrt #(.W(W)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s4),
		.rad     (sum_s4),
		.out_vld (sq_vld),
		.root    (sq_root)
	);

	side_t side_sq [W];

	always_ff @(posedge clk) begin
		side_sq[0] <= side_s4;
		for (int k = 1; k < W; k++) begin
			side_sq[k] <= side_sq[k-1];
		end
	end

	// stage 5: distance checks, r - dist
	side_t        side_c5;
	logic         v_s5;
	side_t        side_s5;
	logic [W-1:0] dist_s5;
	logic [W-2:0] rem_s5;

	always_comb begin
		side_c5      = side_sq[W-1];
		side_c5.outs = side_sq[W-1].outs && (sq_root != '0) &&
			(sq_root < {1'b0, side_sq[W-1].r});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_c5;
		dist_s5 <= sq_root;
		rem_s5  <= side_sq[W-1].r - sq_root[W-2:0];
	end

	// stage 6: numerators
	logic           v_s6;
	tail_t          tail_s6;
	logic [W-1:0]   dist_s6;
	logic [2*W-3:0] prod_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		tail_s6.hit  <= side_s5.hit;
		tail_s6.outs <= side_s5.outs;
		tail_s6.neg  <= side_s5.neg;
		tail_s6.push <= side_s5.push;
		dist_s6      <= dist_s5;
		for (int i = 0; i < 3; i++) begin
			prod_s6[i] <= side_s5.m[i] * rem_s5;
		end
	end

	logic         dv_vld;
	logic [W-2:0] dv_quo [3];

	bscp_div #(.W(W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s6),
		.num     (prod_s6),
		.den     (dist_s6),
		.out_vld (dv_vld),
		.quo     (dv_quo)
	);

	tail_t tail_dv [W-1];

	always_ff @(posedge clk) begin
		tail_dv[0] <= tail_s6;
		for (int k = 1; k < W - 1; k++) begin
			tail_dv[k] <= tail_dv[k-1];
		end
	end

	// output register
	tail_t             tail_o;
	logic [2:0][W-1:0] qv;
	logic              done_q;
	logic              hit_q;
	logic [W-1:0]      push_q [3];

	assign tail_o = tail_dv[W-2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv[i] = tail_o.neg[i] ? -{1'b0, dv_quo[i]} : {1'b0, dv_quo[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= tail_o.hit || tail_o.outs;
		for (int i = 0; i < 3; i++) begin
			push_q[i] <= tail_o.outs ? qv[i] : tail_o.push[i];
		end
	end

	assign done   = done_q;
	assign hit    = hit_q;
	assign push_x = push_q[0];
	assign push_y = push_q[1];
	assign push_z = push_q[2];

	a_inside_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && side_s3.hit |->
		$onehot({side_s3.push[0] != '0, side_s3.push[1] != '0, side_s3.push[2] != '0}))
		else $error("inside push not on exactly one axis");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> push_x == '0 && push_y == '0 && push_z == '0)
		else $error("push nonzero without hit");

	a_sqrt_align: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 == $past(v_s4, W + 1))
		else $error("square root valid out of step with side line");

	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(v_s6, W))
		else $error("divider valid out of step with side line");

endmodule
